// File: sv/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/ipsa_pkg.sv
// package: table sizes, operation codes, cell record types
`timescale 1ns / 1ps
package ipsa_pkg;
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned MaxTransforms = 2;
  localparam int unsigned SlotW = $clog2(MaxEntries);
  localparam int unsigned CountW = $clog2(MaxEntries + 1);
  localparam logic [1:0] CntLimit = (MaxTransforms < 2) ? 2'(MaxTransforms) : 2'd2;

  typedef enum logic [2:0] {
    OP_FIND = 3'd0, OP_FIND_SPI = 3'd1, OP_ADD = 3'd2, OP_ADD_PEND = 3'd3,
    OP_REM_PEND = 3'd4, OP_REM_SPI = 3'd5, OP_DEACT_SPI = 3'd6, OP_CLEAR = 3'd7
  } op_e;

  typedef struct packed {
    logic [31:0] peer;
    logic [31:0] dstart;
    logic [31:0] mend;
    logic [31:0] spi_a;
    logic [31:0] spi_b;
    logic        pend;
    logic        act;
    logic        rng;
    logic [1:0]  cnt;
  } entry_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] ip;
    logic [31:0] dest;
    logic [31:0] spi;
    logic        inc;
  } key_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic       write;    // write wr_entry at wr_slot
    logic       shift;    // compact: cells at or above sh_slot take the upper neighbor
    logic       deact;    // clear act at wr_slot
    logic [SlotW-1:0] wr_slot;
    logic [SlotW-1:0] sh_slot;
  } cell_ctl_t;
endpackage

// File: sv/ipsa_cell.sv
// one table slot: stored entry, match compare, shift from upper neighbor
`timescale 1ns / 1ps
module ipsa_cell (
  input  logic              clk_i,
  input  logic [ipsa_pkg::SlotW-1:0] idx_i,
  input  ipsa_pkg::key_t    key_i,
  input  ipsa_pkg::cell_ctl_t ctl_i,
  input  ipsa_pkg::entry_t  wr_entry_i,
  input  ipsa_pkg::entry_t  upper_i,
  output ipsa_pkg::entry_t  entry_o,
  output logic              hit_o
);
  import ipsa_pkg::*;

  entry_t e_q;
  logic peer_eq, mask_eq, dst_ok, pend_hit;

  always_comb begin
    peer_eq  = (e_q.peer == key_i.ip);
    mask_eq  = ((key_i.dest & e_q.mend) == (e_q.dstart & e_q.mend));
    dst_ok   = (key_i.dest == 32'd0) ? 1'b1 :
               (e_q.rng ? ((key_i.dest >= e_q.dstart) && (key_i.dest <= e_q.mend))
                        : mask_eq);
    pend_hit = peer_eq && e_q.pend && ((key_i.dest == 32'd0) || mask_eq);
    case (key_i.op)
      OP_FIND:     hit_o = (e_q.pend || e_q.act || key_i.inc) && peer_eq && dst_ok;
      OP_FIND_SPI: hit_o = peer_eq && (((e_q.cnt >= 2'd1) && (e_q.spi_a == key_i.spi)) ||
                                       ((e_q.cnt >= 2'd2) && (e_q.spi_b == key_i.spi)));
      OP_ADD, OP_REM_PEND: hit_o = pend_hit;
      OP_REM_SPI, OP_DEACT_SPI: hit_o = (e_q.spi_a == key_i.spi);
      default:     hit_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.write && (ctl_i.wr_slot == idx_i)) begin
      e_q <= wr_entry_i;
    end else if (ctl_i.deact && (ctl_i.wr_slot == idx_i)) begin
      e_q.act <= 1'b0;
    end else if (ctl_i.shift && (idx_i >= ctl_i.sh_slot)) begin
      e_q <= upper_i;
    end
  end

  assign entry_o = e_q;
endmodule

// File: sv/ipsa_ctrl.sv
// sequencer: latch item, priority select over cell hits, write, deactivate, compact or clear, respond
`timescale 1ns / 1ps
module ipsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ipsa_pkg::key_t     key_d_i,
  input  ipsa_pkg::entry_t   new_d_i,
  output ipsa_pkg::key_t     key_o,
  output ipsa_pkg::entry_t   wr_entry_o,
  input  logic [ipsa_pkg::MaxEntries-1:0] hits_i,
  input  ipsa_pkg::entry_t   sel_entry_i,
  output logic [ipsa_pkg::SlotW-1:0] sel_slot_o,
  output ipsa_pkg::cell_ctl_t ctl_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [5:0]         slot_o,
  output logic               add_failed_o,
  output logic               entry_pending_o,
  output logic               entry_active_out_o,
  output logic [31:0]        entry_spi_first_o,
  output logic [1:0]         entry_num_transforms_o,
  output logic [6:0]         entry_count_o
);
  import ipsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_SCAN = 4'b0010, ST_ACT = 4'b0100, ST_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  key_t   key_q;
  entry_t new_q;
  logic [CountW-1:0] occ_q, occ_d;
  logic [SlotW-1:0] first_q, first_d;
  logic any_q, any_d;
  logic found_q, fail_q;
  logic [SlotW-1:0] slot_q;
  entry_t rep_q;
  logic found_d, fail_d;
  logic [SlotW-1:0] slot_d;
  entry_t rep_d;

  // gate hits to occupied slots, then priority pick lowest
  // the first hit is picked during scan and held for the action cycle
  always_comb begin
    any_d = 1'b0;
    first_d = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (hits_i[i] && (CountW'(i) < occ_q)) begin
        any_d = 1'b1;
        first_d = SlotW'(i);
      end
    end
  end

  logic full;
  assign full = (occ_q == CountW'(MaxEntries));
  logic reuse;
  assign reuse = (key_q.op == OP_ADD) && any_q;
  logic [SlotW-1:0] app_slot;
  assign app_slot = occ_q[SlotW-1:0];

  always_comb begin
    state_d = state_q;
    occ_d = occ_q;
    ctl_o = '0;
    ctl_o.wr_slot = reuse ? first_q : app_slot;
    ctl_o.sh_slot = first_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: state_d = ST_ACT;
      ST_ACT: begin
        state_d = ST_OUT;
        case (key_q.op)
          OP_ADD, OP_ADD_PEND: begin
            if (reuse || !full) begin
              ctl_o.write = 1'b1;
              if (!reuse) occ_d = occ_q + 1'b1;
            end
          end
          OP_REM_PEND, OP_REM_SPI: if (any_q) begin
            ctl_o.shift = 1'b1;
            occ_d = occ_q - 1'b1;
          end
          OP_DEACT_SPI: if (any_q) begin
            ctl_o.deact = 1'b1;
            ctl_o.wr_slot = first_q;
          end
          OP_CLEAR: occ_d = '0;
          default: ;
        endcase
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q <= '0;
    end else begin
      state_q <= state_d;
      occ_q <= occ_d;
    end
  end

  always_comb begin
    wr_entry_o = new_q;
    if (key_q.op == OP_ADD_PEND) begin
      wr_entry_o.spi_a = '0;
      wr_entry_o.spi_b = '0;
      wr_entry_o.pend = 1'b1;
      wr_entry_o.act = 1'b0;
      wr_entry_o.rng = 1'b0;
      wr_entry_o.cnt = '0;
    end
  end

  always_comb begin
    found_d = 1'b0;
    fail_d = 1'b0;
    slot_d = '0;
    rep_d = '0;
    case (key_q.op)
      OP_ADD, OP_ADD_PEND: begin
        if (reuse || !full) begin
          found_d = 1'b1;
          slot_d = reuse ? first_q : app_slot;
          rep_d = wr_entry_o;
        end else begin
          fail_d = 1'b1;
        end
      end
      OP_FIND, OP_FIND_SPI, OP_REM_PEND, OP_REM_SPI: if (any_q) begin
        found_d = 1'b1;
        slot_d = first_q;
        rep_d = sel_entry_i;
      end
      OP_DEACT_SPI: if (any_q) begin
        found_d = 1'b1;
        slot_d = first_q;
        rep_d = sel_entry_i;
        rep_d.act = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      key_q <= key_d_i;
      new_q <= new_d_i;
    end
    if (state_q == ST_SCAN) begin
      any_q <= any_d;
      first_q <= first_d;
    end
    if (state_q == ST_ACT) begin
      found_q <= found_d;
      fail_q <= fail_d;
      slot_q <= slot_d;
      rep_q <= rep_d;
    end
  end

  assign key_o = key_q;
  assign sel_slot_o = first_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign found_o = found_q;
  assign slot_o = 6'(slot_q);
  assign add_failed_o = fail_q;
  assign entry_pending_o = rep_q.pend;
  assign entry_active_out_o = rep_q.act;
  assign entry_spi_first_o = rep_q.spi_a;
  assign entry_num_transforms_o = rep_q.cnt;
  assign entry_count_o = 7'(occ_q);
endmodule

// File: sv/ipsec_sa_table.sv
// top level: cell chain plus sequencer
//   channel | direction | words
//   in      | input     | op, addresses, spis, flags
//   out     | output    | one result word per input word
// an item steps through latch, cell compare with priority
// select, write/compact, then respond, which waits for the output
// reset clears occupancy and sequencer state only; slot contents are undefined until written
// a stalled output holds the block; no new word is taken until it leaves
`timescale 1ns / 1ps
module ipsec_sa_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] ip_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [31:0] mask_end_i,
  input  logic        dest_is_range_i,
  input  logic        active_out_i,
  input  logic        incoming_i,
  input  logic [1:0]  num_transforms_i,
  input  logic [31:0] spi_first_i,
  input  logic [31:0] spi_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [5:0]  slot_o,
  output logic        add_failed_o,
  output logic        entry_pending_o,
  output logic        entry_active_out_o,
  output logic [31:0] entry_spi_first_o,
  output logic [1:0]  entry_num_transforms_o,
  output logic [6:0]  entry_count_o
);
  import ipsa_pkg::*;

  key_t key_d, key;
  entry_t new_d, wr_entry, sel_entry;
  cell_ctl_t ctl;
  logic [MaxEntries-1:0] hits;
  entry_t entries [MaxEntries];
  logic [SlotW-1:0] sel_slot;

  always_comb begin
    key_d.op = op_e'(op_i);
    key_d.ip = ip_address_i;
    key_d.dest = dest_address_i;
    key_d.spi = spi_first_i;
    key_d.inc = incoming_i;
    new_d.peer = ip_address_i;
    new_d.dstart = dest_address_i;
    new_d.mend = mask_end_i;
    new_d.spi_a = spi_first_i;
    new_d.spi_b = spi_second_i;
    new_d.pend = 1'b0;
    new_d.act = active_out_i;
    new_d.rng = dest_is_range_i;
    new_d.cnt = (num_transforms_i > CntLimit) ? CntLimit : num_transforms_i;
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    entry_t upper;
    if (g == MaxEntries - 1) begin : g_top
      assign upper = entries[g];
    end else begin : g_mid
      assign upper = entries[g + 1];
    end
    ipsa_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (SlotW'(g)),
      .key_i      (key),
      .ctl_i      (ctl),
      .wr_entry_i (wr_entry),
      .upper_i    (upper),
      .entry_o    (entries[g]),
      .hit_o      (hits[g])
    );
  end

  assign sel_entry = entries[sel_slot];

  ipsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .key_d_i (key_d), .new_d_i (new_d),
    .key_o (key), .wr_entry_o (wr_entry),
    .hits_i (hits), .sel_entry_i (sel_entry), .sel_slot_o (sel_slot),
    .ctl_o (ctl),
    .out_valid_o, .out_ready_i, .found_o, .slot_o, .add_failed_o,
    .entry_pending_o, .entry_active_out_o, .entry_spi_first_o,
    .entry_num_transforms_o, .entry_count_o
  );
endmodule

// File: sv/ipsa_checker.sv
// port-level checker for the table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipsa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       found_o,
  input logic       add_failed_o,
  input logic [5:0] slot_o,
  input logic [6:0] entry_count_o
);
  `ASSERT_IMP(a_fail_not_found, clk_i, rst_ni, out_valid_o && add_failed_o, !found_o)
  `ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_out_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)
  `ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_o, entry_count_o <= 7'd64)
  `ASSERT_IMP(a_slot_zero, clk_i, rst_ni, out_valid_o && !found_o, slot_o == 6'd0)
endmodule

bind ipsec_sa_table ipsa_checker u_ipsa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .found_o, .add_failed_o, .slot_o, .entry_count_o
);

// File: verif/ipsec_sa_table_checker.sv
// checker: table predictor and result comparison for ipsec_sa_table
`timescale 1ns / 1ps
module ipsec_sa_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] ip_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [31:0] mask_end_i,
  input  logic        dest_is_range_i,
  input  logic        active_out_i,
  input  logic        incoming_i,
  input  logic [1:0]  num_transforms_i,
  input  logic [31:0] spi_first_i,
  input  logic [31:0] spi_second_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [5:0]  slot_i,
  input  logic        add_failed_i,
  input  logic        entry_pending_i,
  input  logic        entry_active_out_i,
  input  logic [31:0] entry_spi_first_i,
  input  logic [1:0]  entry_num_transforms_i,
  input  logic [6:0]  entry_count_i,
  output int          fail_count_o,
  output int          pending_words_o
);
  import ipsa_pkg::*;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic        add_failed;
    logic        pend;
    logic        act;
    logic [31:0] spi;
    logic [1:0]  cnt;
    logic [6:0]  count;
  } sa_result_t;

  entry_t     sa_tbl[MaxEntries];
  int         sa_occ;
  sa_result_t expected_q[$];

  function automatic bit mask_match(entry_t e, logic [31:0] d);
    return (d & e.mend) == (e.dstart & e.mend);
  endfunction

  function automatic bit pend_match(entry_t e, logic [31:0] ip, logic [31:0] d);
    return e.peer == ip && e.pend && (d == 0 || mask_match(e, d));
  endfunction

  function automatic void fill_result(ref sa_result_t r, input int s);
    r.found = 1'b1;
    r.slot = 6'(s);
    r.pend = sa_tbl[s].pend;
    r.act = sa_tbl[s].act;
    r.spi = sa_tbl[s].spi_a;
    r.cnt = sa_tbl[s].cnt;
  endfunction

  function automatic void drop_slot(int s);
    for (int k = s; k < sa_occ - 1; k++) sa_tbl[k] = sa_tbl[k + 1];
    sa_occ--;
  endfunction

  function automatic sa_result_t predict_sa_op(op_e op, logic [31:0] ip, logic [31:0] d,
      logic [31:0] me, logic rng, logic act, logic inc, logic [1:0] ntr,
      logic [31:0] s1, logic [31:0] s2);
    sa_result_t r;
    int s;
    bit hit;
    logic [1:0] cn;
    r = '0;
    hit = 0;
    cn = (ntr > CntLimit) ? CntLimit : ntr;
    case (op)
      OP_FIND: begin
        for (int i = 0; i < sa_occ && !hit; i++) begin
          entry_t e = sa_tbl[i];
          if (!e.pend && !inc && !e.act) continue;
          if (e.peer != ip) continue;
          if (d == 0) hit = 1;
          else if (e.rng) hit = d >= e.dstart && d <= e.mend;
          else hit = mask_match(e, d);
          if (hit) fill_result(r, i);
        end
      end
      OP_FIND_SPI: begin
        for (int i = 0; i < sa_occ && !hit; i++) begin
          if (sa_tbl[i].peer != ip) continue;
          hit = (sa_tbl[i].cnt >= 1 && sa_tbl[i].spi_a == s1) ||
                (sa_tbl[i].cnt >= 2 && sa_tbl[i].spi_b == s1);
          if (hit) fill_result(r, i);
        end
      end
      OP_ADD, OP_ADD_PEND: begin
        s = sa_occ;
        if (op == OP_ADD)
          for (int i = 0; i < sa_occ; i++)
            if (pend_match(sa_tbl[i], ip, d)) begin
              s = i;
              break;
            end
        if (s == sa_occ && sa_occ >= MaxEntries) begin
          r.add_failed = 1'b1;
        end else begin
          if (s == sa_occ) sa_occ++;
          sa_tbl[s].peer = ip;
          sa_tbl[s].dstart = d;
          sa_tbl[s].mend = me;
          if (op == OP_ADD) begin
            sa_tbl[s].spi_a = s1;
            sa_tbl[s].spi_b = s2;
            sa_tbl[s].pend = 0;
            sa_tbl[s].act = act;
            sa_tbl[s].rng = rng;
            sa_tbl[s].cnt = cn;
          end else begin
            sa_tbl[s].spi_a = '0;
            sa_tbl[s].spi_b = '0;
            sa_tbl[s].pend = 1;
            sa_tbl[s].act = 0;
            sa_tbl[s].rng = 0;
            sa_tbl[s].cnt = '0;
          end
          fill_result(r, s);
        end
      end
      OP_REM_PEND: begin
        for (int i = 0; i < sa_occ; i++)
          if (pend_match(sa_tbl[i], ip, d)) begin
            fill_result(r, i);
            drop_slot(i);
            break;
          end
      end
      OP_REM_SPI, OP_DEACT_SPI: begin
        for (int i = 0; i < sa_occ; i++)
          if (sa_tbl[i].spi_a == s1) begin
            if (op == OP_REM_SPI) begin
              fill_result(r, i);
              drop_slot(i);
            end else begin
              sa_tbl[i].act = 0;
              fill_result(r, i);
            end
            break;
          end
      end
      default: sa_occ = 0;
    endcase
    r.count = 7'(sa_occ);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  assign pending_words_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_occ <= 0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          sa_result_t w;
          w = expected_q.pop_front();
          if (found_i !== w.found) report_mismatch("found", found_i, w.found);
          if (slot_i !== w.slot) report_mismatch("slot", slot_i, w.slot);
          if (add_failed_i !== w.add_failed)
            report_mismatch("add_failed", add_failed_i, w.add_failed);
          if (entry_pending_i !== w.pend)
            report_mismatch("entry_pending", entry_pending_i, w.pend);
          if (entry_active_out_i !== w.act)
            report_mismatch("entry_active_out", entry_active_out_i, w.act);
          if (entry_spi_first_i !== w.spi)
            report_mismatch("entry_spi_first", entry_spi_first_i, w.spi);
          if (entry_num_transforms_i !== w.cnt)
            report_mismatch("entry_num_transforms", entry_num_transforms_i, w.cnt);
          if (entry_count_i !== w.count)
            report_mismatch("entry_count", entry_count_i, w.count);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_sa_op(op_e'(op_i), ip_address_i, dest_address_i,
            mask_end_i, dest_is_range_i, active_out_i, incoming_i, num_transforms_i,
            spi_first_i, spi_second_i));
    end
  end

endmodule

// File: verif/ipsec_sa_table_tb.sv
// testbench top: stimulus, handshake pacing and verdict for ipsec_sa_table
`timescale 1ns / 1ps
module ipsec_sa_table_tb;
  import ipsa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [31:0] ip_address_i = '0;
  logic [31:0] dest_address_i = '0;
  logic [31:0] mask_end_i = '0;
  logic        dest_is_range_i = 1'b0;
  logic        active_out_i = 1'b0;
  logic        incoming_i = 1'b0;
  logic [1:0]  num_transforms_i = '0;
  logic [31:0] spi_first_i = '0;
  logic [31:0] spi_second_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [5:0]  slot_o;
  logic        add_failed_o;
  logic        entry_pending_o;
  logic        entry_active_out_o;
  logic [31:0] entry_spi_first_o;
  logic [1:0]  entry_num_transforms_o;
  logic [6:0]  entry_count_o;

  int fail_count;
  int words_waiting;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int unsigned cycle_count = 0;

  // small pools so finds and removes actually hit
  logic [31:0] peer_pool[4] = '{32'h0a00_0001, 32'hc0a8_0102, 32'hffff_ffff, 32'h0000_0001};
  logic [31:0] spi_pool[4] = '{32'h0000_0100, 32'hdead_beef, 32'hffff_ffff, 32'h0000_0001};

  ipsec_sa_table u_dut (.*);

  ipsec_sa_table_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .ip_address_i,
    .dest_address_i, .mask_end_i, .dest_is_range_i, .active_out_i, .incoming_i,
    .num_transforms_i, .spi_first_i, .spi_second_i, .out_valid_i(out_valid_o),
    .out_ready_i, .found_i(found_o), .slot_i(slot_o), .add_failed_i(add_failed_o),
    .entry_pending_i(entry_pending_o), .entry_active_out_i(entry_active_out_o),
    .entry_spi_first_i(entry_spi_first_o),
    .entry_num_transforms_i(entry_num_transforms_o), .entry_count_i(entry_count_o),
    .fail_count_o(fail_count), .pending_words_o(words_waiting)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid drops only while the sender idles, so back-to-back words keep it high
  task automatic send_word(op_e op, logic [31:0] ip, logic [31:0] d, logic [31:0] me,
      logic rng, logic act, logic inc, logic [1:0] ntr, logic [31:0] s1, logic [31:0] s2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    ip_address_i <= ip;
    dest_address_i <= d;
    mask_end_i <= me;
    dest_is_range_i <= rng;
    active_out_i <= act;
    incoming_i <= inc;
    num_transforms_i <= ntr;
    spi_first_i <= s1;
    spi_second_i <= s2;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] pick_addr(int mode);
    case (mode)
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return {24'h0a0000, 8'($urandom_range(15))};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word();
    int r;
    op_e op;
    logic [31:0] ip;
    logic [31:0] s1;
    r = $urandom_range(99);
    if (r < 30) op = OP_ADD;
    else if (r < 42) op = OP_ADD_PEND;
    else if (r < 60) op = OP_FIND;
    else if (r < 72) op = OP_FIND_SPI;
    else if (r < 80) op = OP_REM_PEND;
    else if (r < 89) op = OP_REM_SPI;
    else if (r < 98) op = OP_DEACT_SPI;
    else op = OP_CLEAR;
    ip = ($urandom_range(9) == 0) ? $urandom : peer_pool[$urandom_range(3)];
    s1 = ($urandom_range(9) == 0) ? $urandom : spi_pool[$urandom_range(3)];
    send_word(op, ip, pick_addr($urandom_range(3)),
        ($urandom_range(1) ? pick_addr($urandom_range(3)) : 32'hffff_ff00),
        1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
        s1, ($urandom_range(1) ? spi_pool[$urandom_range(3)] : $urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty table, each op, skip rule, range and mask checks, reuse, full table
    send_word(OP_FIND, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0);
    send_word(OP_ADD_PEND, 32'h0a00_0001, 32'h0a00_0000, 32'hffff_ff00, 0, 0, 0, 0, 0, 0);
    send_word(OP_FIND, 32'h0a00_0001, 32'h0a00_0005, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_ADD, 32'h0a00_0001, 32'h0a00_0007, 32'h0, 1, 1, 0, 3,
        32'hffff_ffff, 32'hdead_beef);
    send_word(OP_ADD, 32'hffff_ffff, 32'h1000_0000, 32'h2000_0000, 1, 0, 0, 2,
        32'h0000_0100, 32'h0000_0200);
    send_word(OP_FIND, 32'hffff_ffff, 32'h1800_0000, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_FIND, 32'hffff_ffff, 32'h1800_0000, 0, 0, 0, 1, 0, 0, 0);
    send_word(OP_FIND, 32'hffff_ffff, 32'h2000_0001, 0, 0, 0, 1, 0, 0, 0);
    send_word(OP_FIND_SPI, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 32'h0000_0200, 0);
    send_word(OP_FIND_SPI, 32'h0a00_0001, 0, 0, 0, 0, 0, 0, 32'hdead_beef, 0);
    send_word(OP_DEACT_SPI, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0);
    send_word(OP_FIND, 32'h0a00_0001, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_ADD_PEND, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_REM_PEND, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_REM_SPI, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0);
    send_word(OP_REM_SPI, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678, 0);
    for (int i = 0; i < MaxEntries + 1; i++)
      send_word(OP_ADD_PEND, 32'(i), 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_ADD, 32'h5, 0, 0, 0, 1, 0, 1, 32'h77, 0);
    send_word(OP_ADD, 32'h9999, 0, 0, 0, 1, 0, 1, 32'h77, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // random, with three pacing phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 26 : 0;
      for (int n = 0; n < 610; n++) begin
        if (ph == 2 && n == 100) recv_hold = 1'b1;
        random_word();
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_waiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (recv_hold);
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ipsa_pkg.sv
sv/ipsa_cell.sv
sv/ipsa_ctrl.sv
sv/ipsec_sa_table.sv
sv/ipsa_checker.sv
verif/ipsec_sa_table_checker.sv
verif/ipsec_sa_table_tb.sv
